// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/pcc_pkg.sv =====
// shared types and constants for the palette color cycler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int PALETTE_ENTRIES_DEFAULT = 256;
    localparam int CYCLE_SPAN = 32;
    localparam int CELL_AW = $clog2(CYCLE_SPAN);
    localparam int COLOR_W = 24;
    localparam int INDEX_W = 8;
    localparam int CMD_W = 3;
    localparam int MODE_W = 2;

    // cycle modes
    localparam logic [MODE_W-1:0] MODE_CAVES = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CRYPT = 2'd2;

    // slow tick counter values
    localparam logic [1:0] SLOW_RELOAD = 2'd3;
    localparam logic [1:0] SLOW_LAST   = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_RESTORE = 3'd3,
        CMD_CLEAR   = 3'd4
    } pcc_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] entry_index;
        logic [COLOR_W-1:0] in_color;
    } pcc_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] out_color;
        logic               modified_flag;
    } pcc_result_t;

    // per-cell control from the top level
    typedef struct packed {
        logic wr;
        logic restore;
        logic take_up;
        logic take_down;
    } pcc_cell_ctrl_t;

endpackage

// ===== rtl/palette_ram_color_cycler_unit.sv =====
// top level of the palette store with color cycling
// depends on pcc_pkg, pcc_cell and pcc_upper_ram
`timescale 1ns / 1ps

// Usage
//   Command channel: present item with start high; it is taken at any edge where
//   busy is low. busy stays low, so one command can be issued every cycle.
//   Commands: read, write, cycle tick, restore cycling entries, clear modified.
//   Result channel: only a read gives a result. It appears on result in the
//   cycle after the read is taken, marked by done for exactly one cycle; the
//   receiver cannot hold it off. The result comes from the registered
//   read of the upper entry memory and of the cell row.
//   Throughput: 1 command per cycle. Entries 0..31 are a row of cells; a restore
//   reloads all of them at once, a tick shifts a mode-dependent subset.
//   Configuration: cfg_data sets the cycle mode when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. Write it only while idle.
//   Reset: all entries read as zero, backup cleared, modified flag low, mode 0,
//   slow tick counter at 3. No clearing pass is needed; commands are taken in
//   the first cycle after reset.
module palette_ram_color_cycler_unit #(
    parameter int PALETTE_ENTRIES = pcc_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  pcc_pkg::pcc_item_t         item,
    output logic                       done,
    output pcc_pkg::pcc_result_t       result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pcc_pkg::MODE_W-1:0] cfg_data
);
    import pcc_pkg::*;

    localparam int UPPER_DEPTH = PALETTE_ENTRIES - CYCLE_SPAN;
    localparam int UPPER_AW    = (UPPER_DEPTH > 1) ? $clog2(UPPER_DEPTH) : 1;

    logic accept;
    logic is_read;
    logic is_write;
    logic is_tick;
    logic is_restore;
    logic is_clear;
    logic in_range;
    logic in_cells;
    logic slow_used;
    logic slow_expire;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic [1:0]        slow_cnt_reg;
    logic [1:0]        slow_cnt_next;
    logic              dirty_reg;
    logic              dirty_next;

    logic               done_reg;
    logic               rd_in_range_reg;
    logic               rd_in_cells_reg;
    logic               rd_dirty_reg;
    logic [COLOR_W-1:0] rd_cell_reg;
    logic [COLOR_W-1:0] ram_rd_data;

    logic [COLOR_W-1:0] cell_color [CYCLE_SPAN];
    logic [COLOR_W-1:0] up_src     [CYCLE_SPAN];
    logic [COLOR_W-1:0] down_src   [CYCLE_SPAN];
    pcc_cell_ctrl_t     cell_ctrl  [CYCLE_SPAN];

    // command decode
    assign busy       = 1'b0;
    assign cfg_ready  = 1'b1;
    assign accept     = start && !busy;
    assign is_read    = accept && (item.command == CMD_READ);
    assign is_write   = accept && (item.command == CMD_WRITE);
    assign is_tick    = accept && (item.command == CMD_TICK);
    assign is_restore = accept && (item.command == CMD_RESTORE);
    assign is_clear   = accept && (item.command == CMD_CLEAR);
    assign in_range   = (int'(item.entry_index) < PALETTE_ENTRIES);
    assign in_cells   = (item.entry_index < INDEX_W'(CYCLE_SPAN));

    assign slow_used   = (mode_reg == MODE_NEST) || (mode_reg == MODE_CRYPT);
    assign slow_expire = (slow_cnt_reg == SLOW_LAST);

    // mode register, slow tick counter and modified mark
    always_comb
    begin
        mode_next     = mode_reg;
        slow_cnt_next = slow_cnt_reg;
        dirty_next    = dirty_reg;
        if (cfg_valid && cfg_ready)
        begin
            mode_next = cfg_data;
        end
        if (is_tick && slow_used)
        begin
            slow_cnt_next = slow_expire ? SLOW_RELOAD : (slow_cnt_reg - 2'd1);
        end
        if (is_write && in_range)
        begin
            dirty_next = 1'b1;
        end
        else if (is_clear)
        begin
            dirty_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_CAVES;
            slow_cnt_reg <= SLOW_RELOAD;
            dirty_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            slow_cnt_reg <= slow_cnt_next;
            dirty_reg    <= dirty_next;
            done_reg     <= is_read;
        end
    end

    // row of cycling cells with their rotation sources
    for (genvar k = 0; k < CYCLE_SPAN; k++)
    begin : g_cell
        localparam bit IN_LOW  = (k >= 1) && (k <= 15);
        localparam bit IN_HIGH = (k >= 16);
        localparam bit IN_DOWN = (k >= 1);

        if (k == 1)
        begin : g_up_first
            assign up_src[k] = (mode_reg == MODE_NEST) ? cell_color[8] : cell_color[15];
        end
        else if (k == 9)
        begin : g_up_nest
            assign up_src[k] = (mode_reg == MODE_NEST) ? cell_color[15] : cell_color[8];
        end
        else if (k == 16)
        begin : g_up_high
            assign up_src[k] = cell_color[CYCLE_SPAN-1];
        end
        else if (k == 0)
        begin : g_up_zero
            assign up_src[k] = cell_color[k];
        end
        else
        begin : g_up_plain
            assign up_src[k] = cell_color[k-1];
        end

        if (k == CYCLE_SPAN - 1)
        begin : g_down_wrap
            assign down_src[k] = cell_color[1];
        end
        else
        begin : g_down_plain
            assign down_src[k] = cell_color[k+1];
        end

        assign cell_ctrl[k].wr        = is_write && (item.entry_index == INDEX_W'(k));
        assign cell_ctrl[k].restore   = is_restore;
        assign cell_ctrl[k].take_down = is_tick && (mode_reg == MODE_CAVES) && IN_DOWN;
        assign cell_ctrl[k].take_up   = is_tick &&
                                        ((IN_LOW && slow_used && slow_expire) ||
                                         (IN_HIGH && (mode_reg == MODE_CRYPT)));

        pcc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[k]),
            .wr_color   (item.in_color),
            .up_color   (up_src[k]),
            .down_color (down_src[k]),
            .color      (cell_color[k])
        );
    end

    // memory for entries above the cycling range
    if (UPPER_DEPTH > 0)
    begin : g_upper
        logic [UPPER_AW-1:0] upper_addr;

        assign upper_addr = UPPER_AW'(item.entry_index - INDEX_W'(CYCLE_SPAN));

        pcc_upper_ram #(
            .DEPTH (UPPER_DEPTH),
            .AW    (UPPER_AW)
        ) u_upper_ram (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (is_write && in_range && !in_cells),
            .wr_addr (upper_addr),
            .wr_data (item.in_color),
            .rd_en   (is_read && in_range && !in_cells),
            .rd_addr (upper_addr),
            .rd_data (ram_rd_data)
        );
    end
    else
    begin : g_no_upper
        assign ram_rd_data = '0;
    end

    // read capture of cell value and modified mark
    always_ff @(posedge clk)
    begin
        if (is_read)
        begin
            rd_cell_reg     <= cell_color[item.entry_index[CELL_AW-1:0]];
            rd_in_range_reg <= in_range;
            rd_in_cells_reg <= in_cells;
            rd_dirty_reg    <= dirty_reg;
        end
    end

    // result transaction
    assign done                 = done_reg;
    assign result.modified_flag = rd_dirty_reg;
    assign result.out_color     = !rd_in_range_reg ? '0 :
                                  rd_in_cells_reg  ? rd_cell_reg : ram_rd_data;

endmodule

// ===== rtl/pcc_cell.sv =====
// one cycling palette entry: live color plus its backup copy
// depends on pcc_pkg for the control struct and color width
`timescale 1ns / 1ps

module pcc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcc_pkg::pcc_cell_ctrl_t       ctrl,
    input  logic [pcc_pkg::COLOR_W-1:0]   wr_color,
    input  logic [pcc_pkg::COLOR_W-1:0]   up_color,
    input  logic [pcc_pkg::COLOR_W-1:0]   down_color,
    output logic [pcc_pkg::COLOR_W-1:0]   color
);
    import pcc_pkg::*;

    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic [COLOR_W-1:0] backup_reg;
    logic [COLOR_W-1:0] backup_next;

    // write, restore or shift from a neighbor
    always_comb
    begin
        color_next  = color_reg;
        backup_next = backup_reg;
        if (ctrl.wr)
        begin
            color_next  = wr_color;
            backup_next = wr_color;
        end
        else if (ctrl.restore)
        begin
            color_next = backup_reg;
        end
        else if (ctrl.take_up)
        begin
            color_next = up_color;
        end
        else if (ctrl.take_down)
        begin
            color_next = down_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg  <= '0;
            backup_reg <= '0;
        end
        else
        begin
            color_reg  <= color_next;
            backup_reg <= backup_next;
        end
    end

    assign color = color_reg;

endmodule

// ===== rtl/pcc_upper_ram.sv =====
// storage for the non-cycling palette entries, with per-entry valid bits
// depends on pcc_pkg for the color width
`timescale 1ns / 1ps

module pcc_upper_ram #(
    parameter int DEPTH = pcc_pkg::PALETTE_ENTRIES_DEFAULT - pcc_pkg::CYCLE_SPAN,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [pcc_pkg::COLOR_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [pcc_pkg::COLOR_W-1:0] rd_data
);
    import pcc_pkg::*;

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [COLOR_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    // memory array, written and read at one address each
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/pcc_checker.sv =====
// port-level checker for the palette color cycler, bound to the top level
// depends on pcc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcc_checker #(
    parameter int PALETTE_ENTRIES = pcc_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input pcc_pkg::pcc_item_t         item,
    input logic                       done,
    input pcc_pkg::pcc_result_t       result,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [pcc_pkg::MODE_W-1:0] cfg_data
);
    import pcc_pkg::*;

    logic acc_read;
    logic acc_write;
    logic acc_clear;
    logic cfg_seen;
    logic wr_ok;
    logic rd_hit;
    logic color_hit;

    logic [INDEX_W-1:0] index_d1_reg;
    logic [COLOR_W-1:0] in_color_d1_reg;
    logic [COLOR_W-1:0] in_color_d2_reg;

    assign acc_read  = start && !busy && (item.command == CMD_READ);
    assign acc_write = start && !busy && (item.command == CMD_WRITE);
    assign acc_clear = start && !busy && (item.command == CMD_CLEAR);
    assign cfg_seen  = cfg_valid && cfg_ready && (cfg_data == cfg_data);

    // delayed copies of the command fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_d1_reg    <= '0;
            in_color_d1_reg <= '0;
            in_color_d2_reg <= '0;
        end
        else
        begin
            index_d1_reg    <= item.entry_index;
            in_color_d1_reg <= item.in_color;
            in_color_d2_reg <= in_color_d1_reg;
        end
    end

    assign wr_ok     = acc_write && !cfg_seen && (int'(item.entry_index) < PALETTE_ENTRIES);
    assign rd_hit    = acc_read && (item.entry_index == index_d1_reg);
    assign color_hit = result.modified_flag && (result.out_color == in_color_d2_reg);

    // a result transaction follows every read and nothing else
    `ASSERT_NEXT(a_read_gives_result, clk, rst_n, acc_read, done)
    `ASSERT_IMPLIES(a_result_from_read, clk, rst_n, done, $past(acc_read))

    // a read right after a write to the same entry sees the new color
    `ASSERT_NEXT(a_write_then_read, clk, rst_n, wr_ok ##1 rd_hit, color_hit)

    // an entry beyond the palette reads as zero
    `ASSERT_NEXT(a_out_of_range_zero, clk, rst_n, acc_read && (int'(item.entry_index) >= PALETTE_ENTRIES), result.out_color == '0)

    // clear modified drops the flag for the next read
    `ASSERT_NEXT(a_clear_then_read, clk, rst_n, acc_clear ##1 acc_read, !result.modified_flag)

endmodule

bind palette_ram_color_cycler_unit pcc_checker #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_pcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);
